### src/upe_pkg.sv
package upe_pkg;

	// Component rule codes for the mode register
	localparam logic [2:0] MODE_USER_INFO = 3'd0;
	localparam logic [2:0] MODE_HOST      = 3'd1;
	localparam logic [2:0] MODE_PATH      = 3'd2;
	localparam logic [2:0] MODE_QUERY     = 3'd3;
	localparam logic [2:0] MODE_FRAGMENT  = 3'd4;
	localparam logic [2:0] MODE_FULL_URI  = 3'd5;
	localparam logic [2:0] MODE_DATA      = 3'd6;

	localparam logic [2:0] MODE_RESET = MODE_FULL_URI;

	// Queue between classifier and expander
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;

	// One classified input word
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       esc;
	} upe_item_t;

	function automatic logic is_unres(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") ||
			c == "-" || c == "." || c == "_" || c == "~";
	endfunction

	function automatic logic is_gen_delim(input logic [7:0] c);
		return c == ":" || c == "/" || c == "?" || c == "#" ||
			c == "[" || c == "]" || c == "@";
	endfunction

	function automatic logic is_sub_delim(input logic [7:0] c);
		return c == "!" || c == "$" || c == "&" || c == 8'h27 || c == "(" ||
			c == ")" || c == "*" || c == "+" || c == "," || c == ";" ||
			c == "=";
	endfunction

	function automatic logic is_path_class(input logic [7:0] c);
		return is_unres(c) || is_sub_delim(c) || c == CHAR_PERCENT ||
			c == "/" || c == ":" || c == "@";
	endfunction

	// Decide whether a byte goes out as a percent escape under a rule
	function automatic logic needs_escape(input logic [7:0] c, input logic [2:0] mode);
		logic special;
		logic userinfo;
		logic query;
		logic esc;
		special  = (c == CHAR_PERCENT) || (c == CHAR_PLUS);
		userinfo = is_unres(c) || is_sub_delim(c) || c == CHAR_PERCENT || c == ":";
		query    = is_path_class(c) || c == "?";
		case (mode)
			MODE_USER_INFO: esc = !userinfo || special;
			MODE_HOST:      esc = c[7];
			MODE_PATH:      esc = !is_path_class(c) || special;
			MODE_QUERY:     esc = !query || special;
			MODE_FRAGMENT:  esc = !query || special;
			MODE_DATA:      esc = !is_unres(c);
			default:        esc = !is_unres(c) && !is_gen_delim(c) && !is_sub_delim(c);
		endcase
		return esc;
	endfunction

	// Upper-case hex digit for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] ch;
		if (n < 4'd10) begin
			ch = 8'h30 + {4'd0, n};
		end else begin
			ch = 8'h37 + {4'd0, n};
		end
		return ch;
	endfunction

endpackage

### src/upe_front.sv
module upe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  logic                q_full,
	output logic                in_ready,
	output logic                push,
	output upe_pkg::upe_item_t  push_item
);

	logic [2:0] mode_q;

	// Hold the component rule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= upe_pkg::MODE_RESET;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Classify the incoming word and hand it to the queue
	assign in_ready       = !q_full;
	assign push           = in_valid && !q_full;
	assign push_item.data = in_byte;
	assign push_item.last = in_last;
	assign push_item.esc  = upe_pkg::needs_escape(in_byte, mode_q);

endmodule

### src/upe_fifo.sv
module upe_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  upe_pkg::upe_item_t  push_item,
	input  logic                pop,
	output upe_pkg::upe_item_t  pop_item,
	output logic                full,
	output logic                empty
);

	upe_pkg::upe_item_t            mem_q [upe_pkg::QDEPTH];
	logic [upe_pkg::QAW-1:0]       wr_ptr_q;
	logic [upe_pkg::QAW-1:0]       rd_ptr_q;
	logic [upe_pkg::QAW:0]         count_q;

	assign full     = (count_q == (upe_pkg::QAW+1)'(upe_pkg::QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/upe_back.sv
module upe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  upe_pkg::upe_item_t  q_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_char,
	output logic                run_end,
	output logic                string_end
);

	// Remaining escape digits: none, high nibble next, low nibble next
	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_HI,
		PEND_LO
	} pend_t;

	pend_t      pend_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       vld_q;
	logic [7:0] char_q;
	logic       run_q;
	logic       end_q;
	logic       advance;

	assign advance    = !vld_q || out_ready;
	assign pop        = advance && (pend_q == PEND_NONE) && !q_empty;
	assign out_valid  = vld_q;
	assign out_char   = char_q;
	assign run_end    = run_q;
	assign string_end = end_q;

	// Expand one word into output characters, one per cycle while the output is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			vld_q  <= 1'b0;
			byte_q <= '0;
			last_q <= 1'b0;
			char_q <= '0;
			run_q  <= 1'b0;
			end_q  <= 1'b0;
		end else if (advance) begin
			case (pend_q)
				PEND_HI: begin
					vld_q  <= 1'b1;
					char_q <= upe_pkg::hex_char(byte_q[7:4]);
					run_q  <= 1'b0;
					end_q  <= 1'b0;
					pend_q <= PEND_LO;
				end
				PEND_LO: begin
					vld_q  <= 1'b1;
					char_q <= upe_pkg::hex_char(byte_q[3:0]);
					run_q  <= 1'b1;
					end_q  <= last_q;
					pend_q <= PEND_NONE;
				end
				default: begin
					if (q_empty) begin
						vld_q <= 1'b0;
					end else if (q_item.esc) begin
						vld_q  <= 1'b1;
						char_q <= upe_pkg::CHAR_PERCENT;
						run_q  <= 1'b0;
						end_q  <= 1'b0;
						byte_q <= q_item.data;
						last_q <= q_item.last;
						pend_q <= PEND_HI;
					end else begin
						vld_q  <= 1'b1;
						char_q <= q_item.data;
						run_q  <= 1'b1;
						end_q  <= q_item.last;
					end
				end
			endcase
		end
	end

endmodule

### src/uri_percent_encoder.sv
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata[7:0] in_byte, tlast in_last
// m_axis    out  tvalid/tready           tdata[7:0] out_char, tuser run_end, tlast string_end
// cfg       in   cfg_we (no wait)        cfg_wdata[2:0] component_mode
//
// A byte passed through gives one output character; an escaped byte gives three
// ('%', high digit, low digit), each sent through the single-character output register.
// Input bytes are classified on entry and held in a four-word queue, so the
// input keeps flowing while the output stalls until the queue fills.
// Reset (arst_n low) empties the queue and output and sets the full URI rule.
module uri_percent_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,      // component_mode
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_char
	output logic       m_axis_tuser,   // [0] run_end
	output logic       m_axis_tlast    // string_end
);

	upe_pkg::upe_item_t push_item;
	upe_pkg::upe_item_t pop_item;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;

	// Classify incoming words
	upe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.push_item (push_item)
	);

	// Decouple front and back
	upe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Expand into output characters
	upe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_item     (pop_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_char   (m_axis_tdata),
		.run_end    (m_axis_tuser),
		.string_end (m_axis_tlast)
	);

`ifndef NO_ASSERTIONS
	// End of string only on the last character of a byte
	a_end_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tlast || m_axis_tuser))
		else $error("string end without run end");

	// An escape sequence continues without a gap
	a_escape_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tuser) |=> m_axis_tvalid)
		else $error("gap inside escape sequence");

	// Queue never reports full and empty at once
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue full and empty together");

	// No pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");
`endif

endmodule
